// File: sv/hrc_pkg.sv
// shared types and constants of the hardware monitor reading converter
// used by hrc_front, hrc_div_cell and hwmon_reading_converter
package hrc_pkg;

    localparam int CH_W      = 4;
    localparam int RAW_W     = 8;
    localparam int RATIO_W   = 15;
    localparam int VALUE_W   = 29;
    localparam int DIVISOR_W = 16;
    localparam int PROD_W    = RATIO_W + RAW_W;
    localparam int CFG_IDX_W = 3;

    // one restoring division cell per quotient bit
    localparam int DIV_CELLS = VALUE_W;

    localparam logic [CH_W-1:0] VOLT_CH_LAST = 4'd4;
    localparam logic [CH_W-1:0] TEMP_CH_LAST = 4'd7;
    localparam logic [CH_W-1:0] TACH_CH_LAST = 4'd11;
    localparam logic [CH_W-1:0] VCC_CH      = 4'd2;

    localparam logic [RAW_W-1:0]     TEMP_INVALID = 8'h80;
    localparam logic [DIVISOR_W-1:0] TACH_STALLED = 16'hffff;
    localparam logic [VALUE_W-1:0]   TACH_NUMERATOR = 29'd5400000;
    localparam logic signed [VALUE_W:0] ZERO_C_UK      = 30'sd273150000;
    localparam logic signed [VALUE_W:0] MICRO_PER_UNIT = 30'sd1000000;
    localparam logic [9:0]           MV_TO_UV      = 10'd1000;
    // x / 192 == (x >> 6) / 3
    localparam int                   VOLT_SHIFT    = 6;
    localparam logic [DIVISOR_W-1:0] VOLT_DIV_REST = 16'd3;
    localparam logic [DIVISOR_W-1:0] UNIT_DIVISOR  = 16'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO_2V5     = 3'd0,
        CFG_RATIO_VCCP    = 3'd1,
        CFG_RATIO_VCC     = 3'd2,
        CFG_RATIO_5V      = 3'd3,
        CFG_RATIO_12V     = 3'd4,
        CFG_VCC_ALT_RATIO = 3'd5,
        CFG_VCC_ALT_SEL   = 3'd6
    } cfg_idx_e;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio_2v5;
        logic [RATIO_W-1:0] ratio_vccp;
        logic [RATIO_W-1:0] ratio_vcc;
        logic [RATIO_W-1:0] ratio_5v;
        logic [RATIO_W-1:0] ratio_12v;
        logic [RATIO_W-1:0] vcc_alt_ratio;
        logic               vcc_alt_select;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        ratio_2v5:      15'd2500,
        ratio_vccp:     15'd2250,
        ratio_vcc:      15'd3300,
        ratio_5v:       15'd5000,
        ratio_12v:      15'd12000,
        vcc_alt_ratio:  15'd5000,
        vcc_alt_select: 1'b0
    };

    // item moving down the divider chain; word holds the dividend bits still
    // to be consumed in its top end and the quotient bits in its low end
    typedef struct packed {
        logic [CH_W-1:0]      channel;
        logic                 ok;
        logic [DIVISOR_W-1:0] divisor;
        logic [DIVISOR_W-1:0] rem;
        logic [VALUE_W-1:0]   word;
    } div_word_t;

endpackage

// File: sv/hrc_front.sv
// front end: decodes the channel, scales voltages and temperatures and
// sets up dividend and divisor for the divider chain; uses hrc_pkg
module hrc_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  hrc_pkg::cfg_t            cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [hrc_pkg::CH_W-1:0] in_channel,
    input  logic [hrc_pkg::RAW_W-1:0] in_raw_low,
    input  logic [hrc_pkg::RAW_W-1:0] in_raw_high,
    input  logic                     in_bus_failed,
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output hrc_pkg::div_word_t       dn_data
);
    import hrc_pkg::*;

    typedef enum logic [1:0] {
        KIND_VOLT,
        KIND_TEMP,
        KIND_TACH,
        KIND_NONE
    } kind_t;

    typedef struct packed {
        logic [CH_W-1:0]      channel;
        logic                 ok;
        kind_t                kind;
        logic [PROD_W-1:0]    prod;
        logic [VALUE_W-1:0]   temp_uk;
        logic [DIVISOR_W-1:0] count;
    } front_t;

    logic                 a_valid_reg, a_valid_next;
    front_t               a_reg, a_next;
    logic                 a_ready;
    logic                 b_valid_reg, b_valid_next;
    div_word_t            b_reg, b_next;

    logic [RATIO_W-1:0]   base_ratio;
    logic [RATIO_W-1:0]   use_ratio;
    logic                 drop;
    logic [DIVISOR_W-1:0] count;
    logic signed [VALUE_W:0] temp_s;
    logic [PROD_W+9:0]    volt_uv;

    always_comb begin
        case (in_channel)
            4'd0:    base_ratio = cfg.ratio_2v5;
            4'd1:    base_ratio = cfg.ratio_vccp;
            4'd2:    base_ratio = cfg.ratio_vcc;
            4'd3:    base_ratio = cfg.ratio_5v;
            default: base_ratio = cfg.ratio_12v;
        endcase
        use_ratio = base_ratio;
        if (in_channel == VCC_CH && cfg.vcc_alt_ratio != '0 && cfg.vcc_alt_select) begin
            use_ratio = cfg.vcc_alt_ratio;
        end
        drop  = (in_channel <= VOLT_CH_LAST) && (base_ratio == '0);
        count = {in_raw_high, in_raw_low};
        temp_s = ZERO_C_UK
               + $signed({{(VALUE_W + 1 - RAW_W){in_raw_low[RAW_W-1]}}, in_raw_low})
               * MICRO_PER_UNIT;

        a_next.channel = in_channel;
        a_next.prod    = PROD_W'(use_ratio * in_raw_low);
        a_next.temp_uk = temp_s[VALUE_W-1:0];
        a_next.count   = count;
        if (in_channel <= VOLT_CH_LAST) begin
            a_next.kind = KIND_VOLT;
            a_next.ok   = !in_bus_failed;
        end else if (in_channel <= TEMP_CH_LAST) begin
            a_next.kind = KIND_TEMP;
            a_next.ok   = !in_bus_failed && (in_raw_low != TEMP_INVALID);
        end else if (in_channel <= TACH_CH_LAST) begin
            a_next.kind = KIND_TACH;
            a_next.ok   = !in_bus_failed && (count != '0) && (count != TACH_STALLED);
        end else begin
            a_next.kind = KIND_NONE;
            a_next.ok   = 1'b0;
        end
    end

    assign in_ready     = !a_valid_reg || a_ready;
    // a disabled voltage channel is taken and dropped here
    assign a_valid_next = in_ready ? (in_valid && !drop) : a_valid_reg;

    assign a_ready  = !b_valid_reg || dn_ready;

    always_comb begin
        volt_uv         = (PROD_W + 10)'(a_reg.prod) * (PROD_W + 10)'(MV_TO_UV);
        b_next.channel  = a_reg.channel;
        b_next.ok       = a_reg.ok;
        b_next.rem      = '0;
        b_next.divisor  = UNIT_DIVISOR;
        b_next.word     = '0;
        if (a_reg.ok) begin
            case (a_reg.kind)
                KIND_VOLT: begin
                    b_next.word    = VALUE_W'(volt_uv >> VOLT_SHIFT);
                    b_next.divisor = VOLT_DIV_REST;
                end
                KIND_TEMP: begin
                    b_next.word    = a_reg.temp_uk;
                end
                KIND_TACH: begin
                    b_next.word    = TACH_NUMERATOR;
                    b_next.divisor = a_reg.count;
                end
                default: begin
                    b_next.word    = '0;
                end
            endcase
        end
    end

    assign b_valid_next = a_ready ? a_valid_reg : b_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            a_reg <= a_next;
        end
        if (a_ready) begin
            b_reg <= b_next;
        end
    end

    assign dn_valid = b_valid_reg;
    assign dn_data  = b_reg;

endmodule

// File: sv/hrc_div_cell.sv
// one cell of the divider chain: one restoring division step per item
// with its own valid/ready stage register; uses hrc_pkg
module hrc_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               up_valid,
    output logic               up_ready,
    input  hrc_pkg::div_word_t up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output hrc_pkg::div_word_t dn_data
);
    import hrc_pkg::*;

    logic                 valid_reg, valid_next;
    div_word_t            data_reg, data_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    always_comb begin
        trial = {up_data.rem, up_data.word[VALUE_W-1]};
        diff  = trial - {1'b0, up_data.divisor};
        ge    = trial >= {1'b0, up_data.divisor};
        data_next      = up_data;
        // remainder stays below the divisor, so 16 bits suffice
        data_next.rem  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        data_next.word = {up_data.word[VALUE_W-2:0], ge};
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready) begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: sv/hwmon_reading_converter.sv
// top level of the hardware monitor reading converter: config registers,
// front end and divider chain; uses hrc_pkg, hrc_front, hrc_div_cell
//
// usage:
//   s_ channel: one raw reading per item; s_tuser carries channel and the
//   bus-failure flag, s_tdata the low and high raw bytes.
//   m_ channel: one result per item; m_tuser carries channel and valid flag,
//   m_tdata the value (microvolts, microkelvin or rpm).
//   a voltage item whose channel ratio is zero is taken and gives no result.
//   cfg_wr_en/cfg_index/cfg_wdata write one register per clock, no read-back;
//   write only while no item is in flight.
// path: an item passes two front stages, the first loaded at the accepting
// edge, then one cell per quotient bit of the 29-bit restoring divider
// chain, before m_tvalid rises.
// throughput: one item per cycle; every stage has its own valid/ready
// register, so bubbles fill up and items keep entering while a result waits.
// when m_tready is low the chain fills stage by stage and s_tready drops
// only once every stage holds an item. no item is lost or repeated.
// reset: aresetn (synchronous, active low) empties the pipeline and loads
// the default ratios.
module hwmon_reading_converter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // raw_low, raw_high
    input  logic [4:0]                    s_tuser,  // channel, bus_failed
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,  // value, zero fill
    output logic [4:0]                    m_tuser,  // out_channel, is_valid
    input  logic                          cfg_wr_en,
    input  logic [hrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hrc_pkg::RATIO_W-1:0]   cfg_wdata
);
    import hrc_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      vld   [DIV_CELLS+1];
    logic      rdy   [DIV_CELLS+1];
    div_word_t word  [DIV_CELLS+1];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RATIO_2V5:     cfg_next.ratio_2v5      = cfg_wdata;
                CFG_RATIO_VCCP:    cfg_next.ratio_vccp     = cfg_wdata;
                CFG_RATIO_VCC:     cfg_next.ratio_vcc      = cfg_wdata;
                CFG_RATIO_5V:      cfg_next.ratio_5v       = cfg_wdata;
                CFG_RATIO_12V:     cfg_next.ratio_12v      = cfg_wdata;
                CFG_VCC_ALT_RATIO: cfg_next.vcc_alt_ratio  = cfg_wdata;
                CFG_VCC_ALT_SEL:   cfg_next.vcc_alt_select = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hrc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_channel    (s_tuser[3:0]),
        .in_raw_low    (s_tdata[7:0]),
        .in_raw_high   (s_tdata[15:8]),
        .in_bus_failed (s_tuser[4]),
        .dn_valid      (vld[0]),
        .dn_ready      (rdy[0]),
        .dn_data       (word[0])
    );

    for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
        hrc_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (vld[i]),
            .up_ready (rdy[i]),
            .up_data  (word[i]),
            .dn_valid (vld[i+1]),
            .dn_ready (rdy[i+1]),
            .dn_data  (word[i+1])
        );
    end

    assign rdy[DIV_CELLS] = m_tready;
    assign m_tvalid = vld[DIV_CELLS];
    assign m_tdata  = {{(32 - VALUE_W){1'b0}}, word[DIV_CELLS].word};
    assign m_tuser  = {word[DIV_CELLS].ok, word[DIV_CELLS].channel};

    // invalid results carry a zero value
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[4] |-> m_tdata == '0)
        else $error("invalid result with nonzero value");

    // channels past the tachometers never give a valid result
    a_unknown_ch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[3:0] > TACH_CH_LAST) |-> !m_tuser[4])
        else $error("valid result on unknown channel");

    // a tach quotient lies between numerator / 0xfffe and the numerator
    a_tach_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[4] && (m_tuser[3:0] > TEMP_CH_LAST)
        |-> (m_tdata <= 32'(TACH_NUMERATOR)) && (m_tdata >= 32'd82))
        else $error("tach result out of range");

    // a voltage result stays below 2^26 microvolts
    a_volt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[3:0] <= VOLT_CH_LAST) |-> m_tdata[31:26] == '0)
        else $error("voltage result out of range");

    // a stalled result is held until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule
